/* rtl/pse_pkg.sv */
`default_nettype none
// ============================================================================
// pse_pkg: shared types and codes of the postfix stack evaluator
// Token kinds, operator codes, status codes and the command and status
// bundles that join the controller and the datapath.
// ============================================================================
package pse_pkg;

    localparam int unsigned VALUE_W = 32;

    // token kinds
    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;
    localparam logic [2:0] OP_POW = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       take;         // latch the incoming token
        logic       rd_second;    // read address: 0 top, 1 second from top
        logic       cap_b;        // capture read data as right operand / final value
        logic       cap_a;        // capture read data as left operand
        logic       push;         // write the operand on top, advance depth
        logic       pop;          // drop the top entry
        logic       wr_result;    // write arithmetic result over left operand, drop top
        logic       arith_start;  // launch the arithmetic unit
        logic       out_load;     // load the response register
        logic [1:0] out_sts;      // status for the response
        logic       out_hit;      // response carries a final value
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] code;
        logic       full;
        logic       empty;
        logic       lt2;
        logic       b_zero;
        logic       arith_done;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/pse_ram.sv */
`default_nettype none
// ============================================================================
// pse_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/pse_arith.sv */
`default_nettype none
// ============================================================================
// pse_arith: multi-cycle 32-bit integer unit
// Add and subtract straight into the result register, multiply through a registered multiplier,
// signed divide and modulo by a restoring radix-2 loop, power by
// square-and-multiply on the same multiplier.
// ============================================================================
module pse_arith (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [2:0]  i_op,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [31:0]      o_result
);
    import pse_pkg::*;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DIV  = 3'd2;
    localparam logic [2:0] A_FIX  = 3'd3;
    localparam logic [2:0] A_POWM = 3'd4;
    localparam logic [2:0] A_POWS = 3'd5;

    logic [2:0]  r_state;
    logic        r_done;
    logic [31:0] r_res;
    logic [31:0] r_acc;
    logic [31:0] r_sq;
    logic [31:0] r_exp;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_is_mod;

    logic [31:0] w_mul_x;
    logic [31:0] w_prod;
    logic [32:0] w_trial;
    logic [31:0] w_neg_pow;

    // only the low 32 bits of the product are kept, so the result wraps
    assign w_mul_x = (r_state == A_POWS) ? r_sq : r_acc;
    assign w_prod  = w_mul_x * r_sq;
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    // negative exponent: only bases 1 and -1 survive truncation
    always_comb begin
        if (i_a == 32'd1) begin
            w_neg_pow = 32'd1;
        end else if (i_a == 32'hFFFF_FFFF) begin
            w_neg_pow = i_b[0] ? 32'hFFFF_FFFF : 32'd1;
        end else begin
            w_neg_pow = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        case (i_op)
                            OP_ADD: begin
                                r_res  <= i_a + i_b;
                                r_done <= 1'b1;
                            end
                            OP_SUB: begin
                                r_res  <= i_a - i_b;
                                r_done <= 1'b1;
                            end
                            OP_MUL: begin
                                r_acc   <= i_a;
                                r_sq    <= i_b;
                                r_state <= A_MUL;
                            end
                            OP_DIV, OP_MOD: begin
                                r_quo    <= i_a[31] ? (32'd0 - i_a) : i_a;
                                r_dvs    <= i_b[31] ? (32'd0 - i_b) : i_b;
                                r_rem    <= 32'd0;
                                r_cnt    <= 5'd0;
                                r_neg_q  <= i_a[31] ^ i_b[31];
                                r_neg_r  <= i_a[31];
                                r_is_mod <= (i_op == OP_MOD);
                                r_state  <= A_DIV;
                            end
                            OP_POW: begin
                                if (i_b[31]) begin
                                    r_res  <= w_neg_pow;
                                    r_done <= 1'b1;
                                end else begin
                                    r_acc   <= 32'd1;
                                    r_sq    <= i_a;
                                    r_exp   <= i_b;
                                    r_state <= A_POWM;
                                end
                            end
                            default: begin
                                r_res  <= 32'd0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    r_res   <= w_prod;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    if (!w_trial[32]) begin
                        r_rem <= w_trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_quo[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    // quotient truncates toward zero, remainder follows the dividend
                    if (r_is_mod) begin
                        r_res <= r_neg_r ? (32'd0 - r_rem) : r_rem;
                    end else begin
                        r_res <= r_neg_q ? (32'd0 - r_quo) : r_quo;
                    end
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_POWM: begin
                    if (r_exp == 32'd0) begin
                        r_res   <= r_acc;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else begin
                        if (r_exp[0]) begin
                            r_acc <= w_prod;
                        end
                        r_state <= A_POWS;
                    end
                end
                A_POWS: begin
                    r_sq    <= w_prod;
                    r_exp   <= {1'b0, r_exp[31:1]};
                    r_state <= A_POWM;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

/* rtl/pse_datapath.sv */
`default_nettype none
// ============================================================================
// pse_datapath: value stack, operand registers and response register
// Holds the stack RAM and its depth counter, the latched token, the two
// operands, the arithmetic unit and the registered response.
// ============================================================================
module pse_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pse_pkg::t_cmd      i_cmd,
    output pse_pkg::t_sts           o_sts,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_operand_value,
    input  wire logic [2:0]         i_operator_code,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_result_value,
    output logic                    o_result_valid
);
    import pse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

    logic [DW-1:0]      r_depth;
    logic [1:0]         r_kind;
    logic [2:0]         r_code;
    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] r_a;
    logic [VALUE_W-1:0] r_b;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [VALUE_W-1:0] r_result;
    logic               r_hit;

    logic [DW-1:0]      w_top;
    logic [DW-1:0]      w_second;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [VALUE_W-1:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [VALUE_W-1:0] w_rdata;
    logic               w_arith_done;
    logic [VALUE_W-1:0] w_arith_res;

    assign w_top    = r_depth - DW'(1);
    assign w_second = r_depth - DW'(2);

    assign w_we    = i_cmd.push | i_cmd.wr_result;
    assign w_waddr = i_cmd.push ? r_depth[AW-1:0] : w_second[AW-1:0];
    assign w_wdata = i_cmd.push ? r_val : w_arith_res;
    assign w_raddr = i_cmd.rd_second ? w_second[AW-1:0] : w_top[AW-1:0];

    pse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pse_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.arith_start),
        .i_op     (r_code),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (w_arith_done),
        .o_result (w_arith_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_depth <= r_depth + DW'(1);
            end else if (i_cmd.pop || i_cmd.wr_result) begin
                r_depth <= r_depth - DW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind <= i_kind;
            r_code <= i_operator_code;
            r_val  <= i_operand_value;
        end
        if (i_cmd.cap_b) begin
            r_b <= w_rdata;
        end
        if (i_cmd.cap_a) begin
            r_a <= w_rdata;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_sts;
            r_hit    <= i_cmd.out_hit;
            r_result <= i_cmd.out_hit ? r_b : '0;
        end
    end

    assign o_sts.kind       = r_kind;
    assign o_sts.code       = r_code;
    assign o_sts.full       = (r_depth == FULL_DEPTH);
    assign o_sts.empty      = (r_depth == '0);
    assign o_sts.lt2        = (r_depth < DW'(2));
    assign o_sts.b_zero     = (r_b == '0);
    assign o_sts.arith_done = w_arith_done;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = r_result;
    assign o_result_valid = r_hit;

endmodule
`default_nettype wire

/* rtl/pse_ctrl.sv */
`default_nettype none
// ============================================================================
// pse_ctrl: token sequencer of the postfix stack evaluator
// Decodes each token, sequences the stack reads and writes and the
// arithmetic unit, and hands the response to the output register.
// ============================================================================
module pse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire pse_pkg::t_sts i_sts,
    output pse_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);
    import pse_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RD_B   = 3'd2;
    localparam logic [2:0] S_RD_A   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_EXEC   = 3'd5;
    localparam logic [2:0] S_RD_END = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_sts;
    logic [1:0] n_sts;
    logic       r_hit;
    logic       n_hit;

    always_comb begin
        n_state = r_state;
        n_sts   = r_sts;
        n_hit   = r_hit;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_sts   = ST_OK;
                n_hit   = 1'b0;
                n_state = S_FINISH;
                case (i_sts.kind)
                    KIND_OPERAND: begin
                        if (i_sts.full) begin
                            n_sts = ST_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    KIND_OPERATOR: begin
                        if (i_sts.code <= OP_POW) begin
                            if (i_sts.lt2) begin
                                n_sts = ST_UNDERFLOW;
                            end else begin
                                n_state = S_RD_B;
                            end
                        end
                    end
                    KIND_END: begin
                        if (i_sts.empty) begin
                            n_sts = ST_UNDERFLOW;
                        end else begin
                            n_state = S_RD_END;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_RD_B: begin
                o_cmd.cap_b     = 1'b1;
                o_cmd.rd_second = 1'b1;
                n_state         = S_RD_A;
            end
            S_RD_A: begin
                o_cmd.cap_a = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if ((i_sts.code inside {OP_DIV, OP_MOD}) && i_sts.b_zero) begin
                    n_sts   = ST_DIVZERO;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.arith_start = 1'b1;
                    n_state           = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.arith_done) begin
                    o_cmd.wr_result = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_RD_END: begin
                o_cmd.cap_b = 1'b1;
                o_cmd.pop   = 1'b1;
                n_hit       = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sts  = r_sts;
                    o_cmd.out_hit  = r_hit;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sts   <= ST_OK;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sts   <= n_sts;
            r_hit   <= n_hit;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

/* rtl/postfix_stack_evaluator.sv */
`default_nettype none
// ============================================================================
// postfix_stack_evaluator: postfix expression evaluator on a value stack
// Takes one token per request and returns one response per request.
// ============================================================================
//
// One token is processed at a time; a new request is taken as soon as the
// previous response sits in the output register, even if the downstream side
// is still stalling it. An operand push or a stack error goes straight to
// the response; an end token first reads the top entry. An operator reads
// its two operands and runs the arithmetic unit: add and subtract go
// straight to its result register, multiply through the registered product,
// divide and modulo through a radix-2 restoring loop, one quotient bit per
// cycle, and power alternates the accumulate and the square step on the
// single 32x32 multiplier, or with a negative exponent is answered directly.
// The stack lives in a RAM with one write and one registered read port, so
// the two operands come out over two consecutive reads. Values are 32-bit
// two's complement and wrap; division truncates toward zero and the
// remainder takes the sign of the dividend. Any error leaves the stack
// untouched. Reset clears the depth counter, not the stack RAM.
//
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // token request
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_operand_value,
    input  wire logic [2:0]         i_operator_code,
    // response
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_result_value,
    output logic                    o_result_valid
);
    import pse_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: decode, read operands, run the arithmetic unit, respond
    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // stack, operands, arithmetic and the response register
    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_kind),
        .i_operand_value (i_operand_value),
        .i_operator_code (i_operator_code),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_result_value  (o_result_value),
        .o_result_valid  (o_result_valid)
    );

`ifndef SYNTH
    // an accepted request blocks the next one in the cycle after it
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous token still in flight");

    // never overwrite a response the consumer has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("response register overwritten while stalled");

    // a final value only comes with an ok status
    a_hit_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_valid) |-> (o_status == ST_OK))
        else $error("final value reported with an error status");

    // push and result write share the one write port
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push && w_cmd.wr_result))
        else $error("push and result write in the same cycle");
`endif

endmodule
`default_nettype wire
